// File: sv/msw_pkg.sv
// Shared types, constants and the fixed note table of the melody player.
// Used by the top level and by the shared divider; depends on nothing else.
`timescale 1ns / 1ps

package msw_pkg;

    // Default depth of the note memory.
    localparam int NOTE_ROM_DEPTH_DEF = 104;
    // Entries that the fixed table actually defines.
    localparam int ROM_SIZE = 104;
    // Widest supported note memory address.
    localparam int ROM_ADDR_MAX_W = 10;
    localparam int ROM_WORD_W = 20;

    // Shared divider geometry.
    localparam int DIV_NUM_W = 20;
    localparam int DIV_DEN_W = 13;
    localparam int DIV_CNT_W = 5;
    localparam int DIV_STEPS = 20;

    // Half period numerator: half a second in microseconds.
    localparam logic [DIV_NUM_W-1:0] HP_DIVIDEND = 20'd500000;
    localparam logic [9:0] GAP_MS_RESET = 10'd50;

    // Request kinds.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

    // Note frequencies in Hz; a zero frequency marks a rest.
    localparam logic [9:0] F_RS  = 10'd0;
    localparam logic [9:0] F_G3  = 10'd196;
    localparam logic [9:0] F_B3  = 10'd247;
    localparam logic [9:0] F_C4  = 10'd262;
    localparam logic [9:0] F_D4  = 10'd294;
    localparam logic [9:0] F_E4  = 10'd330;
    localparam logic [9:0] F_F4  = 10'd349;
    localparam logic [9:0] F_FS4 = 10'd370;
    localparam logic [9:0] F_G4  = 10'd392;
    localparam logic [9:0] F_GS4 = 10'd415;
    localparam logic [9:0] F_A4  = 10'd440;
    localparam logic [9:0] F_B4  = 10'd494;
    localparam logic [9:0] F_C5  = 10'd523;
    localparam logic [9:0] F_AH  = 10'd880;
    localparam logic [9:0] F_AL  = 10'd440;

    localparam logic [9:0] D100 = 10'd100;
    localparam logic [9:0] D200 = 10'd200;
    localparam logic [9:0] D300 = 10'd300;
    localparam logic [9:0] D400 = 10'd400;
    localparam logic [9:0] D800 = 10'd800;

    // Each entry: frequency in bits 19..10, duration in ms in bits 9..0.
    localparam logic [ROM_WORD_W-1:0] NOTE_ROM [0:ROM_SIZE-1] = '{
        // Melody 0
        {F_G4, D200}, {F_RS, D100}, {F_G4, D200}, {F_A4, D200},
        {F_G4, D200}, {F_RS, D100}, {F_C4, D200}, {F_B3, D400},
        {F_G4, D200}, {F_RS, D100}, {F_G4, D200}, {F_A4, D200},
        {F_G4, D200}, {F_RS, D100}, {F_D4, D200}, {F_C4, D400},
        {F_G4, D200}, {F_RS, D100}, {F_G4, D200}, {F_GS4, D200},
        {F_E4, D200}, {F_RS, D100}, {F_C4, D200}, {F_B3, D200},
        {F_A4, D200}, {F_RS, D100}, {F_FS4, D200}, {F_F4, D200},
        {F_E4, D200}, {F_RS, D100}, {F_D4, D200}, {F_C4, D800},
        // Melody 1
        {F_E4, D200}, {F_D4, D200}, {F_C4, D200}, {F_D4, D200},
        {F_E4, D200}, {F_E4, D200}, {F_E4, D400},
        {F_D4, D200}, {F_D4, D200}, {F_D4, D400},
        {F_E4, D200}, {F_G4, D200}, {F_G4, D400},
        {F_E4, D200}, {F_D4, D200}, {F_C4, D200}, {F_D4, D200},
        {F_E4, D200}, {F_E4, D200}, {F_E4, D200}, {F_E4, D400},
        {F_D4, D200}, {F_D4, D200}, {F_E4, D200}, {F_D4, D200},
        {F_C4, D800},
        // Melody 2
        {F_C4, D300}, {F_RS, D100}, {F_D4, D300}, {F_RS, D100},
        {F_E4, D300}, {F_RS, D100}, {F_F4, D300}, {F_RS, D100},
        {F_G4, D300}, {F_RS, D100}, {F_A4, D300}, {F_RS, D100},
        {F_B4, D300}, {F_RS, D100}, {F_C5, D300}, {F_RS, D100},
        // Melody 3
        {F_AH, D200}, {F_AL, D200}, {F_AH, D200}, {F_AL, D200},
        {F_AH, D200}, {F_AL, D200}, {F_AH, D200}, {F_AL, D200},
        {F_AH, D200}, {F_AL, D200}, {F_AH, D200}, {F_AL, D200},
        {F_AH, D200}, {F_AL, D200}, {F_AH, D200}, {F_AL, D200},
        {F_AH, D200}, {F_AL, D200}, {F_AH, D200}, {F_AL, D200},
        {F_AH, D200}, {F_AL, D200}, {F_AH, D200}, {F_AL, D200},
        {F_AH, D200}, {F_AL, D200}, {F_AH, D200}, {F_AL, D200},
        {F_AH, D200}, {F_AL, D200}
    };

    localparam logic [6:0] MEL_BASE [0:3] = '{7'd0, 7'd32, 7'd58, 7'd74};
    localparam logic [5:0] MEL_LEN  [0:3] = '{6'd32, 6'd26, 6'd16, 6'd30};

    // Table word for a memory address; addresses past the table read as a rest of 0 ms.
    function automatic logic [ROM_WORD_W-1:0] rom_entry(input logic [ROM_ADDR_MAX_W-1:0] addr);
        logic [ROM_WORD_W-1:0] word;
        word = '0;
        if (32'(addr) < ROM_SIZE) begin
            word = NOTE_ROM[addr[6:0]];
        end
        return word;
    endfunction

    // Milliseconds to microseconds.
    function automatic logic [19:0] ms_to_us(input logic [9:0] ms);
        return 20'(ms) * 20'd1000;
    endfunction

endpackage

// File: sv/msw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the note table of the melody player; no package dependencies.
`timescale 1ns / 1ps

module msw_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 104,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/msw_div.sv
// Restoring divider, one quotient bit per cycle, shared by both note divisions.
// Depends on msw_pkg for its widths and request and response types.
`timescale 1ns / 1ps

module msw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  msw_pkg::t_div_req i_req,
    output msw_pkg::t_div_rsp o_rsp
);
    import msw_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   w_rem_sh;
    logic                 w_ge;
    logic [DIV_DEN_W-1:0] w_rem_nx;

    // One trial subtraction of the shifted remainder.
    assign w_rem_sh = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_nx = w_ge ? DIV_DEN_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[DIV_DEN_W-1:0];

    // Control: busy for one step per quotient bit, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_nx;
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: sv/melody_square_wave_player.sv
// Melody player: a tick item passes through the RESP state into the result register.
// A start item, or a tick that ends a note, loads the next note: a note memory read
// (FETCH, then NOTE), plus two divider runs (DIV1, DIV2) for a sounded note.
// One item is in work at a time; the result register frees the input side.
// Reset is synchronous; afterwards the note memory is filled from the table in the
// FILL state, during which no item is taken (gap_ms writes still are).
`timescale 1ns / 1ps

module melody_square_wave_player #(
    parameter int NOTE_ROM_DEPTH = msw_pkg::NOTE_ROM_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_wdata,     // gap_ms
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] melody_id
    input  logic [1:0] s_axis_tuser,    // [1:0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata     // [0] pin_level, [1] busy_res, [6:2] note_number
);
    import msw_pkg::*;

    localparam int ROM_AW = (NOTE_ROM_DEPTH > 1) ? $clog2(NOTE_ROM_DEPTH) : 1;

    // Controller states.
    localparam logic [2:0] ST_FILL  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_NOTE  = 3'd3;
    localparam logic [2:0] ST_DIV1  = 3'd4;
    localparam logic [2:0] ST_DIV2  = 3'd5;
    localparam logic [2:0] ST_RESP  = 3'd6;

    // Note phases.
    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;
    localparam logic [1:0] PH_REST = 2'd3;

    logic [2:0]        r_state,    n_state;
    logic [ROM_AW-1:0] r_fill;
    logic [9:0]        r_gap_ms;
    logic              r_playing,  n_playing;
    logic [1:0]        r_melody,   n_melody;
    logic [4:0]        r_note_idx, n_note_idx;
    logic [1:0]        r_phase,    n_phase;
    logic [19:0]       r_tick_cnt, n_tick_cnt;
    logic [11:0]       r_half_per, n_half_per;
    logic [7:0]        r_loops,    n_loops;
    logic              r_out_valid;
    logic [7:0]        r_out_data;

    logic                  w_rom_re;
    logic [ROM_AW-1:0]     w_rom_raddr;
    logic [ROM_WORD_W-1:0] w_rom_rdata;
    t_div_req              w_div_req;
    t_div_rsp              w_div_rsp;
    logic                  w_accept;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);

    // Note table memory, filled from the package table after reset.
    msw_ram #(
        .WIDTH (ROM_WORD_W),
        .DEPTH (NOTE_ROM_DEPTH)
    ) u_note_rom (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_FILL),
        .i_waddr (r_fill),
        .i_wdata (rom_entry(ROM_ADDR_MAX_W'(r_fill))),
        .i_re    (w_rom_re),
        .i_raddr (w_rom_raddr),
        .o_rdata (w_rom_rdata)
    );

    // Shared divider for half period and loop count.
    msw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Playback sequencer.
    always_comb begin
        logic [19:0] tc_dec;
        logic [7:0]  lp_dec;
        logic [4:0]  nidx;
        logic [6:0]  rom_addr;
        logic [11:0] hp_sat;
        logic [7:0]  lp_sat;
        logic        adv;
        logic        stp;

        n_state    = r_state;
        n_playing  = r_playing;
        n_melody   = r_melody;
        n_note_idx = r_note_idx;
        n_phase    = r_phase;
        n_tick_cnt = r_tick_cnt;
        n_half_per = r_half_per;
        n_loops    = r_loops;
        w_rom_re   = 1'b0;
        w_rom_raddr = '0;
        w_div_req  = '0;
        adv        = 1'b0;
        stp        = 1'b0;
        tc_dec     = (r_tick_cnt != 20'd0) ? r_tick_cnt - 20'd1 : r_tick_cnt;
        lp_dec     = (r_loops != 8'd0) ? r_loops - 8'd1 : r_loops;
        nidx       = r_note_idx + 5'd1;
        rom_addr   = MEL_BASE[r_melody] + 7'(r_note_idx);
        hp_sat     = (w_div_rsp.quotient > 20'd4095) ? 12'hFFF : w_div_rsp.quotient[11:0];
        lp_sat     = (w_div_rsp.quotient > 20'd255) ? 8'hFF : w_div_rsp.quotient[7:0];

        case (r_state)
            ST_FILL: begin
                if (r_fill == ROM_AW'(NOTE_ROM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_RESP;
                    case (s_axis_tuser)
                        REQ_TICK: begin
                            if (r_playing) begin
                                n_tick_cnt = tc_dec;
                                if (tc_dec == 20'd0) begin
                                    case (r_phase)
                                        PH_HIGH: begin
                                            n_phase    = PH_LOW;
                                            n_tick_cnt = 20'(r_half_per);
                                        end
                                        PH_LOW: begin
                                            n_loops = lp_dec;
                                            if (lp_dec != 8'd0) begin
                                                n_phase    = PH_HIGH;
                                                n_tick_cnt = 20'(r_half_per);
                                            end else if (r_gap_ms != 10'd0) begin
                                                n_phase    = PH_GAP;
                                                n_tick_cnt = ms_to_us(r_gap_ms);
                                            end else begin
                                                adv = 1'b1;
                                            end
                                        end
                                        default: begin
                                            adv = 1'b1;
                                        end
                                    endcase
                                end
                            end
                        end
                        REQ_START: begin
                            if (!r_playing) begin
                                n_melody   = (s_axis_tdata <= 8'd3) ? s_axis_tdata[1:0] : 2'd0;
                                n_playing  = 1'b1;
                                n_note_idx = 5'd0;
                                n_phase    = PH_HIGH;
                                n_tick_cnt = 20'd0;
                                n_half_per = 12'd0;
                                n_loops    = 8'd0;
                                n_state    = ST_FETCH;
                            end
                        end
                        REQ_STOP: begin
                            if (r_playing) begin
                                stp = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                // End of melody, or an address past the memory, ends playback.
                if ({1'b0, r_note_idx} >= MEL_LEN[r_melody]) begin
                    stp = 1'b1;
                end else if ({25'd0, rom_addr} >= 32'(NOTE_ROM_DEPTH)) begin
                    stp = 1'b1;
                end else begin
                    w_rom_re    = 1'b1;
                    w_rom_raddr = ROM_AW'(rom_addr);
                    n_state     = ST_NOTE;
                end
            end
            ST_NOTE: begin
                if (w_rom_rdata[19:10] == 10'd0) begin
                    if (w_rom_rdata[9:0] != 10'd0) begin
                        n_phase    = PH_REST;
                        n_tick_cnt = ms_to_us(w_rom_rdata[9:0]);
                        n_state    = ST_RESP;
                    end else begin
                        adv = 1'b1;
                    end
                end else begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = HP_DIVIDEND;
                    w_div_req.divisor  = DIV_DEN_W'(w_rom_rdata[19:10]);
                    n_state            = ST_DIV1;
                end
            end
            ST_DIV1: begin
                // Half period known; start the loop count division.
                if (w_div_rsp.done) begin
                    n_half_per         = hp_sat;
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = ms_to_us(w_rom_rdata[9:0]);
                    w_div_req.divisor  = {hp_sat, 1'b0};
                    n_state            = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (w_div_rsp.done) begin
                    if (lp_sat != 8'd0) begin
                        n_loops    = lp_sat;
                        n_phase    = PH_HIGH;
                        n_tick_cnt = 20'(r_half_per);
                        n_state    = ST_RESP;
                    end else if (r_gap_ms != 10'd0) begin
                        n_phase    = PH_GAP;
                        n_tick_cnt = ms_to_us(r_gap_ms);
                        n_state    = ST_RESP;
                    end else begin
                        adv = 1'b1;
                    end
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Step to the next note; wrapping past the last index ends playback.
        if (adv) begin
            if (nidx == 5'd0) begin
                stp = 1'b1;
            end else begin
                n_note_idx = nidx;
                n_state    = ST_FETCH;
            end
        end

        if (stp) begin
            n_playing  = 1'b0;
            n_note_idx = 5'd0;
            n_phase    = PH_HIGH;
            n_tick_cnt = 20'd0;
            n_half_per = 12'd0;
            n_loops    = 8'd0;
            n_state    = ST_RESP;
        end
    end

    // State registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_fill     <= '0;
            r_gap_ms   <= GAP_MS_RESET;
            r_playing  <= 1'b0;
            r_melody   <= 2'd0;
            r_note_idx <= 5'd0;
            r_phase    <= PH_HIGH;
            r_tick_cnt <= 20'd0;
            r_half_per <= 12'd0;
            r_loops    <= 8'd0;
        end else begin
            r_state    <= n_state;
            r_playing  <= n_playing;
            r_melody   <= n_melody;
            r_note_idx <= n_note_idx;
            r_phase    <= n_phase;
            r_tick_cnt <= n_tick_cnt;
            r_half_per <= n_half_per;
            r_loops    <= n_loops;
            if (r_state == ST_FILL) begin
                r_fill <= r_fill + ROM_AW'(1);
            end
            if (i_cfg_we) begin
                r_gap_ms <= i_cfg_wdata;
            end
        end
    end

    // Result register: one item per accepted input item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_RESP) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESP) begin
            r_out_data <= {1'b0,
                           r_playing ? r_note_idx : 5'd0,
                           r_playing,
                           r_playing && (r_phase == PH_HIGH)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // An accepted item always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("item accepted but sequencer stayed idle");

    // A result never reports a note or a high pin while not playing.
    a_idle_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[6:2] == 5'd0 && !m_axis_tdata[0]))
        else $error("idle result carries note data");

    // The divider only answers while the sequencer waits on it.
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DIV1 || r_state == ST_DIV2))
        else $error("divider done outside a division state");

    // Between items a playing note always has ticks left in its phase.
    a_phase_has_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_playing) |-> (r_tick_cnt != 20'd0))
        else $error("playing with an empty phase counter");

    // A new result is produced only when the register is free.
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP) |-> (!r_out_valid))
        else $error("result register overwritten");
`endif

endmodule

// File: bench/melody_square_wave_player_test.sv
// Self-checking bench for melody_square_wave_player: random item traffic and stalls on both
// stream sides, an in-bench model of the player, and gap_ms changes between phases.
// Depends on msw_pkg and the player RTL only.
`timescale 1ns / 1ps

module melody_square_wave_player_test;

    import msw_pkg::*;

    localparam int IDLE_PCT = 34;
    localparam int ROM_DEPTH = NOTE_ROM_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    typedef enum logic [1:0] {
        TONE_HIGH = 2'd0,
        TONE_LOW  = 2'd1,
        TONE_GAP  = 2'd2,
        TONE_REST = 2'd3
    } t_tone_phase;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] id;
    } t_player_req;

    typedef struct packed {
        logic       pin;
        logic       busy;
        logic [4:0] note;
    } t_player_state;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [9:0] i_cfg_wdata = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;     // [7:0] melody_id
    logic [1:0] s_axis_tuser = '0;     // [1:0] req_type
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [0] pin_level, [1] busy_res, [6:2] note_number

    melody_square_wave_player uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Own copy of the melody table and the player state.
    logic [19:0]   tune_rom [0:ROM_DEPTH-1];
    int unsigned   tune_base [4];
    int unsigned   tune_len [4];
    logic          tune_on;
    logic [1:0]    tune_sel;
    logic [4:0]    note_idx;
    t_tone_phase   tone_phase;
    logic [19:0]   ticks_left;
    logic [11:0]   half_us;
    logic [7:0]    loops_left;
    logic [9:0]    gap_ms_cfg;

    t_player_req   pending_reqs[$];
    t_player_state expected_states[$];
    t_player_req   cur_req;
    logic          in_taken = 1'b0;
    logic          steady = 1'b0;
    int            items_sent = 0;
    int            items_taken = 0;
    int            errors = 0;
    int            states_checked = 0;
    int            low_phases_seen = 0;
    int            starts_taken = 0;

    function automatic void halt_tune();
        tune_on    = 1'b0;
        note_idx   = '0;
        tone_phase = TONE_HIGH;
        ticks_left = '0;
        half_us    = '0;
        loops_left = '0;
    endfunction

    // Set up the note at note_idx; notes, rests and gaps of zero length are passed over.
    function automatic void load_note();
        logic [19:0] word;
        int unsigned hz;
        int unsigned ms;
        int unsigned hp;
        int unsigned lp;
        int unsigned addr;
        for (int guard = 0; guard < 64; guard++) begin
            if (note_idx >= tune_len[tune_sel]) begin
                halt_tune();
                return;
            end
            addr = tune_base[tune_sel] + note_idx;
            if (addr >= ROM_DEPTH) begin
                halt_tune();
                return;
            end
            word = tune_rom[addr];
            hz = word[19:10];
            ms = word[9:0];
            if (hz == 0) begin
                if (ms != 0) begin
                    tone_phase = TONE_REST;
                    ticks_left = 20'(ms * 1000);
                    return;
                end
            end else begin
                hp = 500000 / hz;
                if (hp > 4095) hp = 4095;
                lp = (ms * 1000) / (2 * hp);
                if (lp > 255) lp = 255;
                half_us = 12'(hp);
                if (lp != 0) begin
                    loops_left = 8'(lp);
                    tone_phase = TONE_HIGH;
                    ticks_left = 20'(hp);
                    return;
                end
                if (gap_ms_cfg != 0) begin
                    tone_phase = TONE_GAP;
                    ticks_left = 20'(gap_ms_cfg * 1000);
                    return;
                end
            end
            note_idx = note_idx + 5'd1;
            if (note_idx == 0) begin
                halt_tune();
                return;
            end
        end
        halt_tune();
    endfunction

    function automatic void next_note();
        note_idx = note_idx + 5'd1;
        if (note_idx == 0) halt_tune();
        else load_note();
    endfunction

    // One microsecond of playback; a zero half period runs the low phase at once.
    function automatic void advance_tick();
        logic again;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            if (ticks_left > 0) ticks_left = ticks_left - 20'd1;
            if (ticks_left == 0) begin
                case (tone_phase)
                    TONE_HIGH: begin
                        tone_phase = TONE_LOW;
                        ticks_left = 20'(half_us);
                        again = (half_us == 0);
                    end
                    TONE_LOW: begin
                        if (loops_left > 0) loops_left = loops_left - 8'd1;
                        if (loops_left != 0) begin
                            tone_phase = TONE_HIGH;
                            ticks_left = 20'(half_us);
                        end else if (gap_ms_cfg != 0) begin
                            tone_phase = TONE_GAP;
                            ticks_left = 20'(gap_ms_cfg * 1000);
                        end else begin
                            next_note();
                        end
                    end
                    default: next_note();
                endcase
            end
        end
    endfunction

    // Apply one request item and return the player state that it leaves.
    function automatic t_player_state play_request(input logic [1:0] req, input logic [7:0] id);
        t_player_state res;
        case (req)
            REQ_TICK: if (tune_on) advance_tick();
            REQ_START: begin
                if (!tune_on) begin
                    tune_sel = (id <= 8'd3) ? id[1:0] : 2'd0;
                    halt_tune();
                    tune_on = 1'b1;
                    load_note();
                end
            end
            REQ_STOP: if (tune_on) halt_tune();
            default: ;
        endcase
        res.pin  = tune_on && (tone_phase == TONE_HIGH);
        res.busy = tune_on;
        res.note = tune_on ? note_idx : 5'd0;
        return res;
    endfunction

    // Request driver: inputs change on the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                cur_req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= cur_req.req;
                s_axis_tdata  <= cur_req.id;
                items_sent++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: predict on each accepted request, check each accepted state item.
    always @(posedge i_clk) begin
        t_player_state exp_st;
        in_taken <= i_rst_n && s_axis_tvalid && (s_axis_tready === 1'b1);
        if (i_rst_n && s_axis_tvalid && s_axis_tready === 1'b1) begin
            if (s_axis_tuser == REQ_START && !tune_on) starts_taken++;
            expected_states.push_back(play_request(s_axis_tuser, s_axis_tdata));
            items_taken++;
        end
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (expected_states.size() == 0) begin
                $display("%0t: unexpected state item, expected none, got 0x%02h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                exp_st = expected_states.pop_front();
                states_checked++;
                if (m_axis_tdata[0] !== exp_st.pin) begin
                    $display("%0t: pin_level mismatch, expected %0d, got %0b",
                             $time, exp_st.pin, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[1] !== exp_st.busy) begin
                    $display("%0t: busy_res mismatch, expected %0d, got %0b",
                             $time, exp_st.busy, m_axis_tdata[1]);
                    errors++;
                end
                if (m_axis_tdata[6:2] !== exp_st.note) begin
                    $display("%0t: note_number mismatch, expected %0d, got %0d",
                             $time, exp_st.note, m_axis_tdata[6:2]);
                    errors++;
                end
                if (exp_st.busy && !exp_st.pin) low_phases_seen++;
            end
        end
    end

    task automatic push_req(input logic [1:0] req, input logic [7:0] id);
        t_player_req item;
        item.req = req;
        item.id  = id;
        pending_reqs.push_back(item);
    endtask

    // Mostly start, a run of ticks, then stop; with noise items and ignored starts mixed in.
    task automatic queue_random_phase(input int target);
        int count;
        int run_len;
        logic [7:0] id;
        count = 0;
        while (count < target) begin
            if ($urandom_range(99) < 12) begin
                case ($urandom_range(2))
                    0: push_req(REQ_RESERVED, 8'($urandom_range(255)));
                    1: push_req(REQ_STOP, 8'($urandom_range(255)));
                    default: push_req(REQ_TICK, 8'($urandom_range(255)));
                endcase
            end else begin
                if ($urandom_range(3) == 0) begin
                    // Long run, cut short at the end of the phase.
                    run_len = $urandom_range(400, 700);
                    id = ($urandom_range(1) == 0) ? 8'd3 : 8'($urandom_range(3));
                end else begin
                    run_len = $urandom_range(5, 60);
                    id = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(3));
                end
                if (run_len > target - count) run_len = target - count;
                push_req(REQ_START, id);
                for (int k = 0; k < run_len; k++) begin
                    case ($urandom_range(99))
                        0: push_req(REQ_START, 8'($urandom_range(255)));
                        1: push_req(REQ_RESERVED, 8'($urandom_range(255)));
                        default: push_req(REQ_TICK, 8'($urandom_range(255)));
                    endcase
                end
                if ($urandom_range(9) < 7) push_req(REQ_STOP, 8'($urandom_range(255)));
                count += run_len + 2;
            end
        end
        push_req(REQ_STOP, 8'($urandom_range(255)));
    endtask

    // Wait until every request is taken and every state item has come back, then settle.
    task automatic drain_player();
        while (pending_reqs.size() != 0 || items_taken != items_sent || s_axis_tvalid)
            @(posedge i_clk);
        while (expected_states.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gap(input logic [9:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        gap_ms_cfg   = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stimulus: reset, directed requests, then random phases under several gap settings.
    initial begin
        int unsigned m0_hz [32];
        int unsigned m0_ms [32];
        int unsigned m1_hz [26];
        int unsigned m1_ms [26];
        int unsigned m2_hz [8];

        m0_hz = '{392, 0, 392, 440, 392, 0, 262, 247,
                  392, 0, 392, 440, 392, 0, 294, 262,
                  392, 0, 392, 415, 330, 0, 262, 247,
                  440, 0, 370, 349, 330, 0, 294, 262};
        m0_ms = '{200, 100, 200, 200, 200, 100, 200, 400,
                  200, 100, 200, 200, 200, 100, 200, 400,
                  200, 100, 200, 200, 200, 100, 200, 200,
                  200, 100, 200, 200, 200, 100, 200, 800};
        m1_hz = '{330, 294, 262, 294, 330, 330, 330, 294, 294, 294,
                  330, 392, 392, 330, 294, 262, 294, 330, 330, 330,
                  330, 294, 294, 330, 294, 262};
        m1_ms = '{200, 200, 200, 200, 200, 200, 400, 200, 200, 400,
                  200, 200, 400, 200, 200, 200, 200, 200, 200, 200,
                  400, 200, 200, 200, 200, 800};
        m2_hz = '{262, 294, 330, 349, 392, 440, 494, 523};

        for (int k = 0; k < ROM_DEPTH; k++) tune_rom[k] = '0;
        for (int k = 0; k < 32; k++) tune_rom[k] = {10'(m0_hz[k]), 10'(m0_ms[k])};
        for (int k = 0; k < 26; k++) tune_rom[32 + k] = {10'(m1_hz[k]), 10'(m1_ms[k])};
        for (int k = 0; k < 8; k++) begin
            tune_rom[58 + 2 * k]     = {10'(m2_hz[k]), 10'd300};
            tune_rom[58 + 2 * k + 1] = {10'd0, 10'd100};
        end
        for (int k = 0; k < 30; k++)
            tune_rom[74 + k] = {(k % 2 == 0) ? 10'd880 : 10'd440, 10'd200};
        tune_base = '{0, 32, 58, 74};
        tune_len  = '{32, 26, 16, 30};

        gap_ms_cfg = GAP_MS_RESET;
        tune_sel   = 2'd0;
        halt_tune();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle requests, every melody, ids past 3, start while busy, stops.
        push_req(REQ_TICK, 8'h00);
        push_req(REQ_STOP, 8'hff);
        push_req(REQ_RESERVED, 8'h00);
        push_req(REQ_START, 8'hff);
        push_req(REQ_START, 8'd2);
        push_req(REQ_TICK, 8'hff);
        push_req(REQ_TICK, 8'h00);
        push_req(REQ_RESERVED, 8'hff);
        push_req(REQ_STOP, 8'h00);
        push_req(REQ_START, 8'd1);
        push_req(REQ_TICK, 8'h55);
        push_req(REQ_STOP, 8'h00);
        push_req(REQ_START, 8'd2);
        push_req(REQ_STOP, 8'h00);
        push_req(REQ_START, 8'd3);
        push_req(REQ_TICK, 8'haa);
        push_req(REQ_STOP, 8'h00);
        push_req(REQ_START, 8'd4);
        push_req(REQ_STOP, 8'h00);
        push_req(REQ_START, 8'd0);
        push_req(REQ_STOP, 8'h00);
        push_req(REQ_START, 8'd128);
        push_req(REQ_TICK, 8'h00);
        push_req(REQ_STOP, 8'h00);

        // Directed: a run on melody 3 long enough for the pin to fall.
        push_req(REQ_START, 8'd3);
        for (int k = 0; k < 580; k++) push_req(REQ_TICK, 8'h00);
        push_req(REQ_STOP, 8'h00);
        drain_player();

        write_gap(10'd1000);
        queue_random_phase(80);
        drain_player();

        // Gap of zero, with neither side idling.
        write_gap(10'd0);
        steady = 1'b1;
        queue_random_phase(80);
        drain_player();
        steady = 1'b0;

        write_gap(10'($urandom_range(1, 999)));
        queue_random_phase(80);
        drain_player();

        $display("Checked %0d state items from %0d requests (%0d melody starts), ",
                 states_checked, items_taken, starts_taken);
        $display("with %0d items in a low tone phase, over gap settings 50, 1000, 0 and %0d.",
                 low_phases_seen, gap_ms_cfg);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/msw_pkg.sv
sv/msw_ram.sv
sv/msw_div.sv
sv/melody_square_wave_player.sv
bench/melody_square_wave_player_test.sv
